// ===== hw/rtl/rvpt_pkg.sv =====
// Shared types and constants for the RV32 PC and trap unit.
`timescale 1ns / 1ps

package rvpt_pkg;

   localparam int unsigned CSR_INDEX_W = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRAP_VECTOR     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IRQ_ENABLE_MASK = 8'd1;

   localparam logic [2:0] KIND_SEQ    = 3'd0;
   localparam logic [2:0] KIND_BRANCH = 3'd1;
   localparam logic [2:0] KIND_JAL    = 3'd2;
   localparam logic [2:0] KIND_JALR   = 3'd3;
   localparam logic [2:0] KIND_TRAP   = 3'd4;
   localparam logic [2:0] KIND_MRET   = 3'd5;
   localparam logic [2:0] KIND_WFI    = 3'd6;

   localparam logic [1:0] TRAP_SEL_ECALL  = 2'd0;
   localparam logic [1:0] TRAP_SEL_EBREAK = 2'd1;

   localparam logic [3:0] CAUSE_ECALL  = 4'd11;
   localparam logic [3:0] CAUSE_EBREAK = 4'd3;
   localparam logic [3:0] CAUSE_OTHER  = 4'd2;

   localparam int unsigned MIE_POS  = 3;
   localparam int unsigned MPIE_POS = 7;

   localparam logic [8:0] BRANCH_PENALTY = 9'd34;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] instruction;
      logic [31:0] rs1_value;
      logic        branch_taken;
      logic [31:0] irq_pending;
      logic [7:0]  cycle_cost;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [31:0] link_value;
      logic [31:0] saved_pc;
      logic [3:0]  trap_cause;
      logic [31:0] status_word;
      logic        sleeping;
      logic [31:0] cycle_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0] pc;
      logic [31:0] epc;
      logic [3:0]  cause;
      logic [31:0] mstatus;
      logic [31:0] cycles;
      logic        sleep;
   } arch_state_type;

   typedef struct packed {
      logic [31:0] imm_i;
      logic [31:0] imm_b;
      logic [31:0] imm_j;
   } imm_set_type;

endpackage

// ===== hw/rtl/rvpt_imm_decode.sv =====
// I, B and J immediate extraction from a raw instruction word.
`timescale 1ns / 1ps

module rvpt_imm_decode (
   input  logic [31:0]          instruction,
   output rvpt_pkg::imm_set_type imms
);

   always_comb begin
      imms.imm_i = {{20{instruction[31]}}, instruction[31:20]};
      imms.imm_b = {{20{instruction[31]}}, instruction[7], instruction[30:25],
                    instruction[11:8], 1'b0};
      imms.imm_j = {{12{instruction[31]}}, instruction[19:12], instruction[20],
                    instruction[30:21], 1'b0};
   end

endmodule

// ===== hw/rtl/rvpt_exec.sv =====
// Next-state and result logic for one retired instruction.
`timescale 1ns / 1ps

module rvpt_exec #(
   parameter int unsigned INSTRUCTION_BYTES = 4
) (
   input  rvpt_pkg::req_payload_type item,
   input  rvpt_pkg::arch_state_type  cur,
   input  logic [31:0]               trap_vector,
   input  logic [31:0]               irq_enable_mask,
   output rvpt_pkg::arch_state_type  nxt,
   output rvpt_pkg::rsp_payload_type result
);

   rvpt_pkg::imm_set_type imms;
   logic [31:0]           seq_pc;
   logic [31:0]           jalr_sum;
   logic [31:0]           link;
   logic [8:0]            cost_total;
   logic                  add_cost;
   logic                  irq_wake;

   rvpt_imm_decode u_imm (
      .instruction (item.instruction),
      .imms        (imms)
   );

   assign seq_pc   = cur.pc + 32'(INSTRUCTION_BYTES);
   assign jalr_sum = item.rs1_value + imms.imm_i;
   assign irq_wake = |(item.irq_pending & irq_enable_mask);

   always_comb begin
      nxt        = cur;
      link       = '0;
      add_cost   = 1'b1;
      cost_total = {1'b0, item.cycle_cost};
      unique case (item.kind)
         rvpt_pkg::KIND_BRANCH: begin
            if (item.branch_taken) begin
               nxt.pc     = cur.pc + imms.imm_b;
               cost_total = {1'b0, item.cycle_cost} + rvpt_pkg::BRANCH_PENALTY;
            end else begin
               nxt.pc = seq_pc;
            end
         end
         rvpt_pkg::KIND_JAL: begin
            link   = seq_pc;
            nxt.pc = cur.pc + imms.imm_j;
         end
         rvpt_pkg::KIND_JALR: begin
            link   = seq_pc;
            nxt.pc = {jalr_sum[31:1], 1'b0};
         end
         rvpt_pkg::KIND_TRAP: begin
            nxt.epc                        = cur.pc;
            nxt.pc                         = trap_vector;
            nxt.mstatus[rvpt_pkg::MPIE_POS] = cur.mstatus[rvpt_pkg::MIE_POS];
            nxt.mstatus[rvpt_pkg::MIE_POS]  = 1'b0;
            case (item.instruction[21:20])
               rvpt_pkg::TRAP_SEL_ECALL:  nxt.cause = rvpt_pkg::CAUSE_ECALL;
               rvpt_pkg::TRAP_SEL_EBREAK: nxt.cause = rvpt_pkg::CAUSE_EBREAK;
               default:                   nxt.cause = rvpt_pkg::CAUSE_OTHER;
            endcase
         end
         rvpt_pkg::KIND_MRET: begin
            nxt.pc                          = cur.epc;
            nxt.mstatus[rvpt_pkg::MIE_POS]  = cur.mstatus[rvpt_pkg::MPIE_POS];
            nxt.mstatus[rvpt_pkg::MPIE_POS] = 1'b1;
         end
         rvpt_pkg::KIND_WFI: begin
            if (irq_wake) begin
               nxt.sleep = 1'b0;
               nxt.pc    = seq_pc;
            end else begin
               // hold pc and counter while asleep
               nxt.sleep = 1'b1;
               add_cost  = 1'b0;
            end
         end
         default: nxt.pc = seq_pc;
      endcase
      if (add_cost) begin
         nxt.cycles = cur.cycles + {23'd0, cost_total};
      end
   end

   always_comb begin
      result.next_pc     = nxt.pc;
      result.link_value  = link;
      result.saved_pc    = nxt.epc;
      result.trap_cause  = nxt.cause;
      result.status_word = nxt.mstatus;
      result.sleeping    = nxt.sleep;
      result.cycle_count = nxt.cycles;
   end

endmodule

// ===== hw/rtl/rv32_pc_and_trap_unit.sv =====
// Top level of the RV32 program-counter and machine-mode trap unit.
`timescale 1ns / 1ps
// An accepted request is held in the input stage register; once the result register
// is empty or being drained, the result is written there and rsp_valid is set.
// Throughput: one instruction per cycle while rsp_ready holds; the combinational next-state logic
// between the input stage and the result register sets the rate.
// Reset: synchronous; clears PC, saved PC, cause, status, counter, sleep flag,
// both CSRs and the valid flags. No clearing pass.

module rv32_pc_and_trap_unit #(
   parameter int unsigned INSTRUCTION_BYTES = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  rvpt_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output rvpt_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rvpt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                          csr_wdata
);

   logic                      stage_valid_ff, stage_valid_in;
   rvpt_pkg::req_payload_type stage_item_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   rvpt_pkg::rsp_payload_type rsp_payload_ff;
   rvpt_pkg::arch_state_type  state_ff, state_in;
   rvpt_pkg::rsp_payload_type exec_result;
   logic [31:0]               trap_vector_ff;
   logic [31:0]               irq_mask_ff;
   logic                      advance;
   logic                      req_fire;

   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   rvpt_exec #(
      .INSTRUCTION_BYTES (INSTRUCTION_BYTES)
   ) u_exec (
      .item            (stage_item_ff),
      .cur             (state_ff),
      .trap_vector     (trap_vector_ff),
      .irq_enable_mask (irq_mask_ff),
      .nxt             (state_in),
      .result          (exec_result)
   );

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_fire) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= '0;
         trap_vector_ff <= '0;
         irq_mask_ff    <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         // commit architectural state only as the result is written to the result register
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rvpt_pkg::CSR_TRAP_VECTOR:     trap_vector_ff <= csr_wdata;
               rvpt_pkg::CSR_IRQ_ENABLE_MASK: irq_mask_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_item_ff <= req_payload;
      end
      if (advance) begin
         rsp_payload_ff <= exec_result;
      end
   end

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_trap_loads_vector: assert property (@(posedge clock) disable iff (reset)
      advance && stage_item_ff.kind == rvpt_pkg::KIND_TRAP
      |=> state_ff.pc == $past(trap_vector_ff) && state_ff.epc == $past(state_ff.pc))
      else $error("trap entry did not load the vector and save the pc");

   a_sleep_holds_counter: assert property (@(posedge clock) disable iff (reset)
      advance && stage_item_ff.kind == rvpt_pkg::KIND_WFI && state_in.sleep
      |=> state_ff.cycles == $past(state_ff.cycles) && state_ff.pc == $past(state_ff.pc))
      else $error("sleeping wait changed pc or cycle counter");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      $past(advance) |-> rsp_payload.next_pc == state_ff.pc
                         && rsp_payload.cycle_count == state_ff.cycles)
      else $error("result register and committed state disagree");

endmodule
